### design/mfep_pkg.sv
// Shared constants, types, kind codes and error codes for the MIDI file event parser.
package mfep_pkg;

    localparam int VARLEN_MAX_BYTES_DEF = 4;
    localparam logic [15:0] EVENT_LIMIT_RST = 16'd4096;
    localparam logic [15:0] TRACK_LIMIT_RST = 16'd16;

    localparam logic [0:0] REG_EVENT_LIMIT = 1'd0;
    localparam logic [0:0] REG_TRACK_LIMIT = 1'd1;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_CHANNEL = 3'd1,
        KIND_META    = 3'd2,
        KIND_SYSEX   = 3'd3,
        KIND_TRK_END = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CHUNK_ID  = 3'd1,
        ERR_FORMAT    = 3'd2,
        ERR_FMT0_TRKS = 3'd3,
        ERR_TIMECODE  = 3'd4,
        ERR_TRACKS    = 3'd5,
        ERR_VARLEN    = 3'd6
    } err_t;

    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] SYSEX_F0    = 8'hF0;
    localparam logic [7:0] SYSEX_F7    = 8'hF7;
    localparam logic [7:0] META_EOT    = 8'h2F;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_TSIG   = 8'h58;
    localparam logic [7:0] META_KSIG   = 8'h59;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] track_index;
        logic [27:0] delta_time;
        logic [7:0]  status_byte;
        logic [7:0]  meta_type;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [31:0] value;
        logic [1:0]  header_format;
        logic [15:0] track_total;
        logic        track_ok;
        logic [2:0]  error_code;
    } result_t;

endpackage

### design/midi_file_event_parser.sv
// MIDI file event parser: top level, one file byte per request.
//
// s_axis carries the file: tdata = {file_byte}, tuser = file_start, which
// restarts the parse on that byte. m_axis carries zero or one result per
// input byte; its tdata packs the result fields from kind in the low bits up
// to error_code. cfg_* writes event_limit (index 0) or track_limit
// (index 1); write only while idle.
// Each byte is decoded in the cycle it is accepted and its result lands in
// a single output register; the parser takes one byte per cycle unless the
// output stalls. The input is ready whenever the output register is empty
// or being drained; a stalled receiver holds the result and, once the
// register is full, backpressures the byte stream.
// Reset (aresetn low, synchronous) returns the parser to expecting the
// header id, clears all counters and loads the register defaults.
// Results carry the header, events up to event_limit per track, track ends
// and errors; after an error or the last declared track bytes are consumed silently.
module midi_file_event_parser #(
    parameter int VARLEN_MAX_BYTES = mfep_pkg::VARLEN_MAX_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic         s_axis_tuser,   // [0] file_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // kind, track_index, delta_time, status_byte,
                                         // meta_type, data_one, data_two, value,
                                         // header_format, track_total, track_ok,
                                         // error_code (lowest bit first), 3 pad zeros
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    typedef enum logic [4:0] {
        PH_HID, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_HSKIP, PH_TID, PH_TLEN,
        PH_DELTA, PH_STATUS, PH_CDATA, PH_MTYPE, PH_MLEN, PH_MDATA, PH_SXLEN,
        PH_SXDATA, PH_TSKIP, PH_DONE
    } phase_t;

    localparam int VB_W = $clog2(VARLEN_MAX_BYTES + 1);

    logic [15:0] event_limit_reg, track_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic        idm_reg, idm_next;
    logic [31:0] clen_reg, clen_next;
    logic [32:0] left_reg, left_next;
    logic [27:0] vacc_reg, vacc_next;
    logic [VB_W-1:0] vbytes_reg, vbytes_next;
    logic [27:0] delta_reg, delta_next;
    logic [7:0]  rstat_reg, rstat_next, cstat_reg, cstat_next;
    logic [7:0]  d1_reg, d1_next, d2_reg, d2_next, mtype_reg, mtype_next;
    logic [31:0] mlen_reg, mlen_next, tempo_reg, tempo_next, skip_reg, skip_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [15:0] decl_reg, decl_next, tdone_reg, tdone_next, evcnt_reg, evcnt_next;
    logic        clean_reg, clean_next;

    mfep_pkg::result_t res_reg, res_next;
    logic        res_valid_reg;
    logic        emit;

    logic        accept;
    logic [7:0]  b;

    assign s_axis_tready = !res_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign b             = s_axis_tdata;
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {3'd0, res_reg.error_code, res_reg.track_ok, res_reg.track_total,
                            res_reg.header_format, res_reg.value, res_reg.data_two,
                            res_reg.data_one, res_reg.meta_type, res_reg.status_byte,
                            res_reg.delta_time, res_reg.track_index, res_reg.kind};

    always_comb begin
        phase_t      ph;
        logic [2:0]  fc;
        logic        idm;
        logic [31:0] cl;
        logic [32:0] lf;
        logic [27:0] va;
        logic [VB_W-1:0] vb;
        logic [7:0]  want;
        logic [31:0] shifted;
        logic [15:0] ev_eff;
        logic [15:0] tdn;
        logic        vl_done, vl_long;
        logic [27:0] vl_val;
        logic [VB_W-1:0] vb_inc;
        logic        fin;
        mfep_pkg::kind_t fk;
        logic [7:0]  fmt_t, fd1, fd2;
        logic [31:0] fval;
        logic        te;
        logic [27:0] te_delta;
        logic [7:0]  te_st, te_mt, te_d1, te_d2;
        logic        te_ok;
        logic        fail;
        mfep_pkg::err_t fcode;
        logic [3:0]  hi;
        logic        keep, need2;
        logic        hdr;
        logic [15:0] divw;
        logic        sig;

        // defaults: hold
        fin = 1'b0; fk = mfep_pkg::KIND_CHANNEL; fmt_t = 8'd0; fd1 = 8'd0; fd2 = 8'd0;
        fval = 32'd0; te = 1'b0; te_delta = 28'd0; te_st = 8'd0; te_mt = 8'd0;
        te_d1 = 8'd0; te_d2 = 8'd0; te_ok = 1'b0; fail = 1'b0;
        fcode = mfep_pkg::ERR_NONE; hdr = 1'b0; divw = 16'd0;
        want = 8'd0; shifted = 32'd0; hi = 4'd0; keep = 1'b0; need2 = 1'b0; sig = 1'b0;

        if (s_axis_tuser) begin
            ph = PH_HID; fc = 3'd0; idm = 1'b1; cl = 32'd0; lf = 33'd0; va = 28'd0;
            vb = '0;
            delta_next = 28'd0; rstat_next = 8'd0; cstat_next = 8'd0;
            d1_next = 8'd0; d2_next = 8'd0; mtype_next = 8'd0; mlen_next = 32'd0;
            tempo_next = 32'd0; skip_next = 32'd0; fmt_next = 2'd0; decl_next = 16'd0;
            tdn = 16'd0; evcnt_next = 16'd0; clean_next = 1'b0;
        end else begin
            ph = phase_reg; fc = fcnt_reg; idm = idm_reg; cl = clen_reg; lf = left_reg;
            va = vacc_reg; vb = vbytes_reg;
            delta_next = delta_reg; rstat_next = rstat_reg; cstat_next = cstat_reg;
            d1_next = d1_reg; d2_next = d2_reg; mtype_next = mtype_reg;
            mlen_next = mlen_reg; tempo_next = tempo_reg; skip_next = skip_reg;
            fmt_next = fmt_reg; decl_next = decl_reg; tdn = tdone_reg;
            evcnt_next = evcnt_reg; clean_next = clean_reg;
        end

        if (ph >= PH_DELTA && ph <= PH_TSKIP) lf = lf - 33'd1;

        // shared varlen step
        vl_val  = {va[20:0], b[6:0]};
        vb_inc  = vb + VB_W'(1);
        vl_done = !b[7];
        vl_long = b[7] && (32'(vb_inc) >= 32'(VARLEN_MAX_BYTES));
        shifted = {cl[23:0], b};
        ev_eff  = (event_limit_reg == 16'd0) ? 16'd1 : event_limit_reg;

        phase_next = ph;

        case (ph)
            PH_HID, PH_TID: begin
                case (fc[1:0])
                    2'd0: want = 8'h4D;
                    2'd1: want = 8'h54;
                    2'd2: want = (ph == PH_HID) ? 8'h68 : 8'h72;
                    default: want = (ph == PH_HID) ? 8'h64 : 8'h6B;
                endcase
                if (b != want) idm = 1'b0;
                fc = fc + 3'd1;
                if (fc >= 3'd4) begin
                    if (!idm) begin
                        fail = 1'b1; fcode = mfep_pkg::ERR_CHUNK_ID;
                    end else begin
                        phase_next = (ph == PH_HID) ? PH_HLEN : PH_TLEN;
                        fc = 3'd0; idm = 1'b1; cl = 32'd0;
                    end
                end
            end
            PH_HLEN, PH_TLEN, PH_HFMT, PH_HNTRK, PH_HDIV: begin
                cl = shifted;
                fc = fc + 3'd1;
                if (((ph == PH_HLEN || ph == PH_TLEN) && fc >= 3'd4) ||
                    (ph != PH_HLEN && ph != PH_TLEN && fc >= 3'd2)) begin
                    fc = 3'd0;
                    if (ph == PH_HLEN) begin
                        skip_next = (cl > 32'd6) ? cl - 32'd6 : 32'd0;
                        phase_next = PH_HFMT; cl = 32'd0;
                    end else if (ph == PH_HFMT) begin
                        fmt_next = (cl > 32'd3) ? 2'd3 : cl[1:0];
                        if (cl > 32'd1) begin
                            fail = 1'b1; fcode = mfep_pkg::ERR_FORMAT;
                        end else begin
                            phase_next = PH_HNTRK; cl = 32'd0;
                        end
                    end else if (ph == PH_HNTRK) begin
                        decl_next = cl[15:0];
                        if (fmt_next == 2'd0 && cl[15:0] != 16'd1) begin
                            fail = 1'b1; fcode = mfep_pkg::ERR_FMT0_TRKS;
                        end else begin
                            phase_next = PH_HDIV; cl = 32'd0;
                        end
                    end else if (ph == PH_HDIV) begin
                        divw = cl[15:0];
                        if (divw[15]) begin
                            fail = 1'b1; fcode = mfep_pkg::ERR_TIMECODE;
                        end else if (decl_next > track_limit_reg) begin
                            fail = 1'b1; fcode = mfep_pkg::ERR_TRACKS;
                        end else begin
                            hdr = 1'b1;
                            if (skip_next != 32'd0) phase_next = PH_HSKIP;
                            else if (decl_next == 16'd0) phase_next = PH_DONE;
                            else begin
                                phase_next = PH_TID; idm = 1'b1;
                            end
                            cl = 32'd0;
                        end
                    end else begin
                        lf = {1'b0, cl};
                        evcnt_next = 16'd0; clean_next = 1'b0; rstat_next = 8'd0;
                        va = 28'd0; vb = '0;
                        if (cl == 32'd0) te = 1'b1;
                        else phase_next = PH_DELTA;
                        cl = 32'd0;
                    end
                end
            end
            PH_HSKIP: begin
                skip_next = skip_next - 32'd1;
                if (skip_next == 32'd0) begin
                    if (decl_next == 16'd0) phase_next = PH_DONE;
                    else begin
                        phase_next = PH_TID; fc = 3'd0; idm = 1'b1; cl = 32'd0;
                    end
                end
            end
            PH_DELTA: begin
                va = vl_val; vb = vb_inc;
                if (vl_long) begin
                    fail = 1'b1; fcode = mfep_pkg::ERR_VARLEN;
                end else if (vl_done) begin
                    vb = '0; delta_next = vl_val; va = 28'd0; phase_next = PH_STATUS;
                end
            end
            PH_STATUS, PH_CDATA: begin
                if (ph == PH_STATUS) begin
                    fc = 3'd0; d1_next = 8'd0; d2_next = 8'd0;
                end
                if (ph == PH_STATUS && b[7]) begin
                    cstat_next = b;
                    if (b == mfep_pkg::META_STATUS) begin
                        rstat_next = 8'd0; phase_next = PH_MTYPE;
                    end else if (b == mfep_pkg::SYSEX_F0 || b == mfep_pkg::SYSEX_F7) begin
                        rstat_next = 8'd0; phase_next = PH_SXLEN;
                    end else begin
                        rstat_next = (b < 8'hF0) ? b : 8'd0; phase_next = PH_CDATA;
                    end
                end else begin
                    if (ph == PH_STATUS) cstat_next = rstat_next;
                    hi = cstat_next[7:4];
                    need2 = !(hi == 4'hC || hi == 4'hD);
                    keep = (hi == 4'h8 || hi == 4'h9 || hi == 4'hB);
                    if (fc == 3'd0) d1_next = keep ? b : 8'd0;
                    else d2_next = keep ? b : 8'd0;
                    fc = fc + 3'd1;
                    if (fc >= (need2 ? 3'd2 : 3'd1)) begin
                        fin = 1'b1; fk = mfep_pkg::KIND_CHANNEL;
                        fd1 = d1_next; fd2 = d2_next;
                    end else phase_next = PH_CDATA;
                end
            end
            PH_MTYPE: begin
                mtype_next = b; phase_next = PH_MLEN;
            end
            PH_MLEN, PH_SXLEN: begin
                va = vl_val; vb = vb_inc;
                if (vl_long) begin
                    fail = 1'b1; fcode = mfep_pkg::ERR_VARLEN;
                end else if (vl_done) begin
                    vb = '0;
                    mlen_next = {4'd0, vl_val}; va = 28'd0; tempo_next = 32'd0; fc = 3'd0;
                    skip_next = {4'd0, vl_val};
                    if (vl_val == 28'd0) begin
                        fin = 1'b1;
                        if (ph == PH_MLEN) fk = mfep_pkg::KIND_META;
                        else begin
                            fk = mfep_pkg::KIND_SYSEX; fval = {4'd0, vl_val};
                        end
                    end else phase_next = (ph == PH_MLEN) ? PH_MDATA : PH_SXDATA;
                end
            end
            PH_MDATA: begin
                if (mtype_next == mfep_pkg::META_TEMPO) tempo_next = {tempo_next[23:0], b};
                else if (fc == 3'd0) d1_next = b;
                else if (fc == 3'd1) d2_next = b;
                if (fc < 3'd2) fc = fc + 3'd1;
                skip_next = skip_next - 32'd1;
                if (skip_next == 32'd0) begin
                    fin = 1'b1; fk = mfep_pkg::KIND_META;
                end
            end
            PH_SXDATA: begin
                skip_next = skip_next - 32'd1;
                if (skip_next == 32'd0) begin
                    fin = 1'b1; fk = mfep_pkg::KIND_SYSEX; fval = mlen_next;
                end
            end
            PH_TSKIP: begin
                if ($signed(lf) <= 0) te = 1'b1;
            end
            default: ;
        endcase

        if (fin && fk == mfep_pkg::KIND_META) begin
            fmt_t = mtype_next;
            sig = (mtype_next == mfep_pkg::META_TSIG || mtype_next == mfep_pkg::META_KSIG);
            fd1 = sig ? d1_next : 8'd0;
            fd2 = sig ? d2_next : 8'd0;
            fval = (mtype_next == mfep_pkg::META_TEMPO) ? tempo_next : mlen_next;
        end

        res_next = '0;
        res_next.header_format = fmt_next;
        res_next.track_total   = decl_next;
        res_next.track_index   = tdn;
        emit = 1'b0;

        if (fin) begin
            clean_next = (fk == mfep_pkg::KIND_META) && (mtype_next == mfep_pkg::META_EOT) &&
                         (mlen_next == 32'd0);
            if (evcnt_next != 16'hFFFF) evcnt_next = evcnt_next + 16'd1;
            if ($signed(lf) <= 0) begin
                te = 1'b1; te_delta = delta_next; te_st = cstat_next; te_mt = fmt_t;
                te_d1 = fd1; te_d2 = fd2; te_ok = clean_next;
            end else begin
                phase_next = (evcnt_next >= ev_eff) ? PH_TSKIP : PH_DELTA;
                va = 28'd0; vb = '0;
                emit = 1'b1;
                res_next.kind = fk; res_next.delta_time = delta_next;
                res_next.status_byte = cstat_next; res_next.meta_type = fmt_t;
                res_next.data_one = fd1; res_next.data_two = fd2; res_next.value = fval;
            end
        end

        if (te) begin
            emit = 1'b1;
            res_next.kind = mfep_pkg::KIND_TRK_END; res_next.delta_time = te_delta;
            res_next.status_byte = te_st; res_next.meta_type = te_mt;
            res_next.data_one = te_d1; res_next.data_two = te_d2;
            res_next.value = {16'd0, evcnt_next}; res_next.track_ok = te_ok;
            if (tdn != 16'hFFFF) tdn = tdn + 16'd1;
            if (tdn >= decl_next) phase_next = PH_DONE;
            else begin
                phase_next = PH_TID; fc = 3'd0; idm = 1'b1; cl = 32'd0;
            end
        end

        if (hdr) begin
            emit = 1'b1;
            res_next.kind = mfep_pkg::KIND_HEADER; res_next.value = {17'd0, divw[14:0]};
        end

        if (fail) begin
            emit = 1'b1;
            phase_next = PH_DONE;
            res_next = '0;
            res_next.kind = mfep_pkg::KIND_ERROR; res_next.error_code = fcode;
            res_next.header_format = fmt_next; res_next.track_total = decl_next;
            res_next.track_index = tdn;
        end

        fcnt_next = fc; idm_next = idm; clen_next = cl; left_next = lf;
        vacc_next = va; vbytes_next = vb; tdone_next = tdn;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_limit_reg <= mfep_pkg::EVENT_LIMIT_RST;
            track_limit_reg <= mfep_pkg::TRACK_LIMIT_RST;
            phase_reg <= PH_HID; fcnt_reg <= 3'd0; idm_reg <= 1'b1; clen_reg <= 32'd0;
            left_reg <= 33'd0; vacc_reg <= 28'd0; vbytes_reg <= '0; delta_reg <= 28'd0;
            rstat_reg <= 8'd0; cstat_reg <= 8'd0; d1_reg <= 8'd0; d2_reg <= 8'd0;
            mtype_reg <= 8'd0; mlen_reg <= 32'd0; tempo_reg <= 32'd0; skip_reg <= 32'd0;
            fmt_reg <= 2'd0; decl_reg <= 16'd0; tdone_reg <= 16'd0; evcnt_reg <= 16'd0;
            clean_reg <= 1'b0; res_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == mfep_pkg::REG_EVENT_LIMIT) event_limit_reg <= cfg_data;
                else track_limit_reg <= cfg_data;
            end
            if (accept && emit) res_valid_reg <= 1'b1;
            else if (m_axis_tready) res_valid_reg <= 1'b0;
            if (accept) begin
                phase_reg <= phase_next; fcnt_reg <= fcnt_next; idm_reg <= idm_next;
                clen_reg <= clen_next; left_reg <= left_next; vacc_reg <= vacc_next;
                vbytes_reg <= vbytes_next; delta_reg <= delta_next;
                rstat_reg <= rstat_next; cstat_reg <= cstat_next; d1_reg <= d1_next;
                d2_reg <= d2_next; mtype_reg <= mtype_next; mlen_reg <= mlen_next;
                tempo_reg <= tempo_next; skip_reg <= skip_next; fmt_reg <= fmt_next;
                decl_reg <= decl_next; tdone_reg <= tdone_next; evcnt_reg <= evcnt_next;
                clean_reg <= clean_next;
                if (emit) res_reg <= res_next;
            end
        end
    end

endmodule
